>>> rtl/lphs_pkg.sv
// Shared types and constants for the linear probing hash set.
// Used by the slot table, the top level and the port checker.
package lphs_pkg;

	localparam int KEY_W   = 32;
	localparam int LIMIT_W = 4;
	localparam int SCNT_W  = 11;
	localparam int OUT_W   = 16;

	localparam logic [KEY_W-1:0]   HASH_MULT   = 32'd2654435761;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd7;

	localparam logic OPC_QUERY  = 1'b0;
	localparam logic OPC_INSERT = 1'b1;

	// result item, present in the lowest bit
	typedef struct packed {
		logic [SCNT_W-1:0] stored_count;
		logic              full_res;
		logic              inserted;
		logic              present;
	} res_t;

endpackage

>>> rtl/lphs_table.sv
// Slot table: single write port, one registered read port.
// Depends on lphs_pkg for the key width.
module lphs_table #(
	parameter int DEPTH = 1024
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [$clog2(DEPTH)-1:0]    wr_addr,
	input  logic [lphs_pkg::KEY_W-1:0]  wr_data,
	input  logic [$clog2(DEPTH)-1:0]    rd_addr,
	output logic [lphs_pkg::KEY_W-1:0]  rd_data
);

	logic [lphs_pkg::KEY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> rtl/linear_probe_hash_set_core.sv
// Linear probing hash set of non-zero 32-bit keys, top level; uses lphs_pkg and lphs_table.
// An item goes from accept through HASH, PROBE (k slots probed, 1..CAPACITY) and DONE to m_tvalid;
//   key zero skips PROBE. One item at a time: the next is taken once the result is registered,
//   later while a finished result waits behind one not yet taken. One slot read per probe cycle.
// Reset clears control at once, then a clearing pass over all CAPACITY slots empties the
//   table; no item is taken during it, cfg writes are.
module linear_probe_hash_set_core #(
	parameter int CAPACITY = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [lphs_pkg::KEY_W-1:0]     s_tdata,  // key
	input  logic                           s_tuser,  // opcode
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [lphs_pkg::OUT_W-1:0]     m_tdata,  // present, inserted, full_res, stored_count[10:0], pad
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lphs_pkg::LIMIT_W-1:0]   cfg_data  // load_limit_tenths
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int LIM_W = CNT_W + 4;
	localparam logic [IDX_W-1:0] MULT_LO = lphs_pkg::HASH_MULT[IDX_W-1:0];
	localparam logic [LIM_W-1:0] CAP_L   = LIM_W'(CAPACITY);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_HASH  = 3'd2;
	localparam logic [2:0] ST_PROBE = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]                       state_q;
	logic [IDX_W-1:0]                 clr_idx_q;
	logic                             op_q;
	logic [lphs_pkg::KEY_W-1:0]       key_q;
	logic [IDX_W-1:0]                 idx_q;
	logic [IDX_W-1:0]                 n_q;
	logic                             lim_full_q;
	logic                             present_q;
	logic                             inserted_q;
	logic                             full_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic [lphs_pkg::LIMIT_W-1:0]     limit_q;
	logic                             m_tvalid_q;
	logic [lphs_pkg::OUT_W-1:0]       m_tdata_q;

	logic [IDX_W-1:0]                 home;
	logic [IDX_W-1:0]                 idx_nxt;
	logic [IDX_W-1:0]                 rd_addr;
	logic [lphs_pkg::KEY_W-1:0]       rd_data;
	logic                             wr_en;
	logic [IDX_W-1:0]                 wr_addr;
	logic [lphs_pkg::KEY_W-1:0]       wr_data;
	logic                             hit;
	logic                             empty;
	logic                             last;
	logic                             do_ins;
	logic [LIM_W-1:0]                 cnt_inc;
	logic [LIM_W-1:0]                 need;
	logic [LIM_W-1:0]                 lim;
	logic [CNT_W+lphs_pkg::SCNT_W-1:0] cnt_ext;
	lphs_pkg::res_t                   res;
	logic                             out_free;

	assign home    = key_q[IDX_W-1:0] * MULT_LO;
	assign idx_nxt = IDX_W'(idx_q + 1'b1);
	assign rd_addr = (state_q == ST_HASH) ? home : idx_nxt;

	assign hit    = (rd_data == key_q);
	assign empty  = (rd_data == '0);
	assign last   = (n_q == '1);
	assign do_ins = (state_q == ST_PROBE) && !hit && empty
	                && (op_q == lphs_pkg::OPC_INSERT) && !lim_full_q;

	assign wr_en   = (state_q == ST_CLEAR) || do_ins;
	assign wr_addr = (state_q == ST_CLEAR) ? clr_idx_q : idx_q;
	assign wr_data = (state_q == ST_CLEAR) ? '0 : key_q;

	assign cnt_inc = LIM_W'(cnt_q) + 1'b1;
	assign need    = LIM_W'(cnt_inc << 3) + LIM_W'(cnt_inc << 1);
	assign lim     = CAP_L * LIM_W'(limit_q);

	assign cnt_ext = {{lphs_pkg::SCNT_W{1'b0}}, cnt_q};
	always_comb begin
		res.present      = present_q;
		res.inserted     = inserted_q;
		res.full_res     = full_q;
		res.stored_count = cnt_ext[lphs_pkg::SCNT_W-1:0];
	end

	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign cfg_ready = 1'b1;

	lphs_table #(
		.DEPTH (CAPACITY)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= lphs_pkg::LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_idx_q  <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= IDX_W'(clr_idx_q + 1'b1);
					if (clr_idx_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					state_q <= (key_q == '0) ? ST_DONE : ST_PROBE;
				end
				ST_PROBE: begin
					if (hit || empty || last) begin
						state_q <= ST_DONE;
					end
					if (do_ins) begin
						cnt_q <= CNT_W'(cnt_q + 1'b1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q  <= s_tuser;
				key_q <= s_tdata;
			end
			ST_HASH: begin
				idx_q      <= home;
				n_q        <= '0;
				lim_full_q <= (need >= lim);
				present_q  <= 1'b0;
				inserted_q <= 1'b0;
				full_q     <= 1'b0;
			end
			ST_PROBE: begin
				if (hit) begin
					present_q <= 1'b1;
				end else if (empty || last) begin
					if (op_q == lphs_pkg::OPC_INSERT) begin
						inserted_q <= do_ins;
						full_q     <= !do_ins;
					end
				end else begin
					idx_q <= idx_nxt;
					n_q   <= IDX_W'(n_q + 1'b1);
				end
			end
			ST_DONE: begin
				if (out_free) begin
					m_tdata_q <= lphs_pkg::OUT_W'(res);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/lphs_checker.sv
// Port checker for linear_probe_hash_set_core, attached by bind.
// Depends on lphs_pkg for port widths.
module lphs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [lphs_pkg::OUT_W-1:0]    m_tdata
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !m_tvalid && !s_tready)
		else $error("output or input active in reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tdata[2:0]))
		else $error("more than one result flag set");

	a_present_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[0] || m_tdata[1]) |-> m_tdata[13:3] != 11'd0 || m_tdata[1] == 1'b0)
		else $error("inserted with zero count");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is in flight");

endmodule

bind linear_probe_hash_set_core lphs_checker u_lphs_checker (.*);
